/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// next-cycle implication
`define PCTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

/* rtl/pctl_pkg.sv */
// ----------------------------------------------------------------------------
// pctl_pkg
// Shared constants, command codes and control/status types of the cache table.
// ----------------------------------------------------------------------------
package pctl_pkg;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned PROBE_LIMIT = 16;
  localparam int unsigned DATA_WIDTH  = 64;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned WDATA_W = 64;
  localparam int unsigned LIFE_W  = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIME_W  = 48;

  // digest bits folded into the remainder per cycle
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_PURGE  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic take;
    logic walk_init;
    logic mod_step;
    logic seek_step;
    logic scan_step;
    logic purge_step;
    logic sweep_step;
    logic commit;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic mod_done;
    logic probe_stop;
    logic probe_miss;
    logic scan_stop;
    logic purge_end;
    logic sweep_end;
    cmd_e cmd;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

/* rtl/probing_cache_table_ttl_lru.sv */
// ----------------------------------------------------------------------------
// probing_cache_table_ttl_lru
// Linear-probing hashed cache with lifetime expiry and LRU eviction.
// ----------------------------------------------------------------------------
// Usage: one command item enters on in_valid_i/in_ready_o, one result item
// leaves on out_valid_o/out_ready_i. One item is processed at a time; the
// next item is taken while the previous result still waits at the output.
// Steps per item, from accept to result valid; the simple dual-port slot RAM
// is walked one address per cycle:
//   lookup/remove/insert: digest remainder, then a probe of up to
//     PROBE_LIMIT+1 slots (one slot a cycle, registered read), then commit.
//   insert needing eviction: adds an LRU scan of up to CAPACITY slots.
//   purge: one pass over all slots; clear: a sweep of all slots; tick: no walk.
// Reset: a clearing pass over all CAPACITY slots marks every slot free; inputs
// are not taken until it ends. Counters and time reset to zero.
// A stalled receiver holds the result; the block finishes the item in hand
// and then waits before publishing the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module probing_cache_table_ttl_lru #(
  parameter int unsigned CAPACITY    = pctl_pkg::CAPACITY,
  parameter int unsigned PROBE_LIMIT = pctl_pkg::PROBE_LIMIT,
  parameter int unsigned DATA_WIDTH  = pctl_pkg::DATA_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pctl_pkg::CMD_W-1:0]    cmd_i,
  input  logic [pctl_pkg::KEY_W-1:0]    key_digest_i,
  input  logic [pctl_pkg::WDATA_W-1:0]  write_data_i,
  input  logic [pctl_pkg::LIFE_W-1:0]   lifetime_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [pctl_pkg::WDATA_W-1:0]  read_data_o,
  output logic [pctl_pkg::SLOT_W-1:0]   slot_index_o,
  output logic                          evicted_o,
  output logic [pctl_pkg::CNT_W-1:0]    hits_seen_o,
  output logic [pctl_pkg::CNT_W-1:0]    misses_seen_o,
  output logic [pctl_pkg::CNT_W-1:0]    evictions_seen_o
);

  pctl_pkg::ctl_t ctl;
  pctl_pkg::sts_t sts;

  pctl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  pctl_datapath #(
    .CAPACITY    (CAPACITY),
    .PROBE_LIMIT (PROBE_LIMIT),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cmd_i            (cmd_i),
    .key_digest_i     (key_digest_i),
    .write_data_i     (write_data_i),
    .lifetime_i       (lifetime_i),
    .found_o          (found_o),
    .read_data_o      (read_data_o),
    .slot_index_o     (slot_index_o),
    .evicted_o        (evicted_o),
    .hits_seen_o      (hits_seen_o),
    .misses_seen_o    (misses_seen_o),
    .evictions_seen_o (evictions_seen_o)
  );

  `PCTL_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)
  `PCTL_ASSERT_NOW(a_evict_has_slot, out_valid_o && evicted_o, found_o)
  `PCTL_ASSERT_NOW(a_data_only_on_hit, out_valid_o && (read_data_o != '0), found_o)

endmodule

/* rtl/pctl_ram.sv */
// ----------------------------------------------------------------------------
// pctl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pctl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/pctl_ctrl.sv */
// ----------------------------------------------------------------------------
// pctl_ctrl
// Sequencer: steps the datapath through remainder, probe, scan, purge, sweep and commit.
// ----------------------------------------------------------------------------
module pctl_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pctl_pkg::CMD_W-1:0]     in_cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pctl_pkg::ctl_t                 ctl_o,
  input  pctl_pkg::sts_t                 sts_i
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_MOD    = 9'b000000100,
    S_PROBE  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_PURGE  = 9'b000100000,
    S_SWEEP  = 9'b001000000,
    S_COMMIT = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_INIT: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_end) state_d = S_IDLE;
      end
      S_IDLE: begin
        ctl_o.walk_init = 1'b1;
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          case (pctl_pkg::cmd_e'(in_cmd_i))
            pctl_pkg::CMD_LOOKUP,
            pctl_pkg::CMD_INSERT,
            pctl_pkg::CMD_REMOVE: state_d = S_MOD;
            pctl_pkg::CMD_PURGE:  state_d = S_PURGE;
            pctl_pkg::CMD_CLEAR:  state_d = S_SWEEP;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        ctl_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = S_PROBE;
      end
      S_PROBE: begin
        ctl_o.seek_step = 1'b1;
        if (sts_i.probe_stop) begin
          state_d = S_COMMIT;
        end else if (sts_i.probe_miss) begin
          if (sts_i.cmd == pctl_pkg::CMD_INSERT) begin
            ctl_o.walk_init = 1'b1;
            state_d         = S_SCAN;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_stop) state_d = S_COMMIT;
      end
      S_PURGE: begin
        ctl_o.purge_step = 1'b1;
        if (sts_i.purge_end) state_d = S_DONE;
      end
      S_SWEEP: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_end) state_d = S_DONE;
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (ctl_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/pctl_datapath.sv */
// ----------------------------------------------------------------------------
// pctl_datapath
// Slot RAM, remainder unit, probe/scan address walker, counters and results.
// ----------------------------------------------------------------------------
module pctl_datapath #(
  parameter int unsigned CAPACITY    = pctl_pkg::CAPACITY,
  parameter int unsigned PROBE_LIMIT = pctl_pkg::PROBE_LIMIT,
  parameter int unsigned DATA_WIDTH  = pctl_pkg::DATA_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pctl_pkg::ctl_t                  ctl_i,
  output pctl_pkg::sts_t                  sts_o,
  input  logic [pctl_pkg::CMD_W-1:0]      cmd_i,
  input  logic [pctl_pkg::KEY_W-1:0]      key_digest_i,
  input  logic [pctl_pkg::WDATA_W-1:0]    write_data_i,
  input  logic [pctl_pkg::LIFE_W-1:0]     lifetime_i,
  output logic                            found_o,
  output logic [pctl_pkg::WDATA_W-1:0]    read_data_o,
  output logic [pctl_pkg::SLOT_W-1:0]     slot_index_o,
  output logic                            evicted_o,
  output logic [pctl_pkg::CNT_W-1:0]      hits_seen_o,
  output logic [pctl_pkg::CNT_W-1:0]      misses_seen_o,
  output logic [pctl_pkg::CNT_W-1:0]      evictions_seen_o
);

  localparam int unsigned KW   = pctl_pkg::KEY_W;
  localparam int unsigned TW   = pctl_pkg::TIME_W;
  localparam int unsigned LW   = pctl_pkg::LIFE_W;
  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = IW + 1;
  localparam int unsigned NMAX = (CAPACITY > PROBE_LIMIT) ? CAPACITY : PROBE_LIMIT;
  localparam int unsigned NW   = $clog2(NMAX + 1);
  localparam int unsigned MCW  = $clog2(pctl_pkg::MOD_STEPS);

  // entry layout, low to high: payload, life, touched, born, tag, live
  localparam int unsigned P_LIFE  = DW;
  localparam int unsigned P_TOUCH = P_LIFE + LW;
  localparam int unsigned P_BORN  = P_TOUCH + TW;
  localparam int unsigned P_TAG   = P_BORN + TW;
  localparam int unsigned P_LIVE  = P_TAG + KW;
  localparam int unsigned EW      = P_LIVE + 1;

  // item
  pctl_pkg::cmd_e  cmd_q;
  logic [KW-1:0]   key_q;
  logic [DW-1:0]   wdata_q;
  logic [LW-1:0]   life_q;

  // remainder unit
  logic [KW-1:0]   dig_sh_q;
  logic [CW-1:0]   rem_q, rem_d;
  logic [MCW-1:0]  mod_cnt_q;
  logic            mod_done;

  // walker
  logic [IW-1:0]   addr_q, addr_nx, ev_addr_q;
  logic [NW-1:0]   issue_q;
  logic            ev_vld_q, ev_last_q, rd_en, last_issue, walking;

  // selection
  logic [IW-1:0]   sel_addr_q, min_addr_q;
  logic [EW-1:0]   sel_entry_q;
  logic            sel_found_q, evicted_q, have_min_q;
  logic [TW-1:0]   min_q;

  // state
  logic [TW-1:0]                tick_q, tick_d;
  logic [pctl_pkg::CNT_W-1:0]   hit_q, hit_d, miss_q, miss_d, evict_q, evict_d;

  // ram
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data, rdata;

  // evaluation of the entry read last cycle
  logic            e_live, stale, free, match, probe_hit, newer_min;
  logic [TW-1:0]   age;

  // results
  logic            found_q, res_found, ev_out_q;
  logic [pctl_pkg::WDATA_W-1:0]       rdata_out_q;
  logic [pctl_pkg::SLOT_W-1:0]        idx_out_q;
  logic [pctl_pkg::WDATA_W+DW-1:0]    rd_ext;
  logic [pctl_pkg::SLOT_W+IW-1:0]     idx_ext;

  pctl_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (addr_q),
    .rd_data_o (rdata)
  );

  // shift-subtract remainder, MOD_BITS digest bits per cycle, MSB first
  always_comb begin
    rem_d = rem_q;
    for (int i = 0; i < int'(pctl_pkg::MOD_BITS); i++) begin
      rem_d = {rem_d[CW-2:0], dig_sh_q[KW-1-i]};
      if (rem_d >= CW'(CAPACITY)) rem_d = rem_d - CW'(CAPACITY);
    end
  end
  assign mod_done = ctl_i.mod_step && (mod_cnt_q == MCW'(pctl_pkg::MOD_STEPS - 1));

  assign addr_nx    = (addr_q == IW'(CAPACITY - 1)) ? '0 : addr_q + 1'b1;
  assign walking    = ctl_i.seek_step || ctl_i.scan_step || ctl_i.purge_step;
  assign rd_en      = ctl_i.seek_step ? (issue_q <= NW'(PROBE_LIMIT))
                                      : (issue_q <  NW'(CAPACITY));
  assign last_issue = ctl_i.seek_step ? (issue_q == NW'(PROBE_LIMIT))
                                      : (issue_q == NW'(CAPACITY - 1));

  assign e_live    = rdata[P_LIVE];
  assign age       = tick_q - rdata[P_BORN +: TW];
  assign stale     = age > {{(TW-LW){1'b0}}, rdata[P_LIFE +: LW]};
  assign free      = !e_live;
  assign match     = e_live && (rdata[P_TAG +: KW] == key_q) && !stale;
  assign probe_hit = free ? (cmd_q == pctl_pkg::CMD_INSERT) : match;
  assign newer_min = !have_min_q || (rdata[P_TOUCH +: TW] < min_q);

  assign sts_o.mod_done   = mod_done;
  assign sts_o.probe_stop = ev_vld_q && (free || match);
  assign sts_o.probe_miss = ev_vld_q && ev_last_q && !(free || match);
  assign sts_o.scan_stop  = ev_vld_q && (free || ev_last_q);
  assign sts_o.purge_end  = ev_vld_q && ev_last_q;
  assign sts_o.sweep_end  = (issue_q == NW'(CAPACITY - 1));
  assign sts_o.cmd        = cmd_q;

  // walker control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      issue_q    <= '0;
      ev_vld_q   <= 1'b0;
      ev_last_q  <= 1'b0;
      have_min_q <= 1'b0;
      mod_cnt_q  <= '0;
    end else begin
      if (ctl_i.take) mod_cnt_q <= '0;
      else if (ctl_i.mod_step) mod_cnt_q <= mod_cnt_q + 1'b1;

      if (ctl_i.walk_init) begin
        addr_q     <= '0;
        issue_q    <= '0;
        ev_vld_q   <= 1'b0;
        have_min_q <= 1'b0;
      end else if (mod_done) begin
        addr_q   <= rem_d[IW-1:0];
        issue_q  <= '0;
        ev_vld_q <= 1'b0;
      end else if (walking) begin
        ev_vld_q  <= rd_en;
        ev_last_q <= last_issue;
        if (rd_en) begin
          addr_q  <= addr_nx;
          issue_q <= issue_q + 1'b1;
        end
        if (ctl_i.scan_step && ev_vld_q && !free && newer_min) have_min_q <= 1'b1;
      end else if (ctl_i.sweep_step) begin
        addr_q  <= addr_nx;
        issue_q <= issue_q + 1'b1;
      end
    end
  end

  // item and selection registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q       <= pctl_pkg::cmd_e'(cmd_i);
      key_q       <= key_digest_i;
      wdata_q     <= write_data_i[DW-1:0];
      life_q      <= lifetime_i;
      dig_sh_q    <= key_digest_i;
      rem_q       <= '0;
      sel_found_q <= 1'b0;
      evicted_q   <= 1'b0;
    end
    if (ctl_i.mod_step) begin
      dig_sh_q <= dig_sh_q << pctl_pkg::MOD_BITS;
      rem_q    <= rem_d;
    end
    if (walking) ev_addr_q <= addr_q;

    if (ctl_i.seek_step && sts_o.probe_stop) begin
      sel_addr_q  <= ev_addr_q;
      sel_found_q <= probe_hit;
      sel_entry_q <= rdata;
    end else if (ctl_i.seek_step && sts_o.probe_miss) begin
      sel_found_q <= 1'b0;
    end

    if (ctl_i.scan_step && ev_vld_q) begin
      if (free) begin
        sel_addr_q <= ev_addr_q;
      end else begin
        if (newer_min) begin
          min_q      <= rdata[P_TOUCH +: TW];
          min_addr_q <= ev_addr_q;
        end
        if (ev_last_q) sel_addr_q <= newer_min ? ev_addr_q : min_addr_q;
      end
      if (sts_o.scan_stop) begin
        sel_found_q <= 1'b1;
        evicted_q   <= 1'b1;
      end
    end
  end

  // single write port: sweep, purge write-back, or final commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = '0;
    if (ctl_i.sweep_step) begin
      wr_en = 1'b1;
    end else if (ctl_i.purge_step && ev_vld_q && e_live && stale) begin
      wr_en           = 1'b1;
      wr_addr         = ev_addr_q;
      wr_data         = rdata;
      wr_data[P_LIVE] = 1'b0;
    end else if (ctl_i.commit) begin
      wr_addr = sel_addr_q;
      case (cmd_q)
        pctl_pkg::CMD_LOOKUP: begin
          wr_en                  = sel_found_q;
          wr_data                = sel_entry_q;
          wr_data[P_TOUCH +: TW] = tick_q;
        end
        pctl_pkg::CMD_REMOVE: begin
          wr_en = sel_found_q;
        end
        pctl_pkg::CMD_INSERT: begin
          wr_en   = 1'b1;
          wr_data = {1'b1, key_q, tick_q, tick_q, life_q, wdata_q};
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // counters and time
  always_comb begin
    tick_d  = tick_q;
    hit_d   = hit_q;
    miss_d  = miss_q;
    evict_d = evict_q;
    if (ctl_i.finish) begin
      case (cmd_q)
        pctl_pkg::CMD_LOOKUP: begin
          if (sel_found_q) hit_d = pctl_pkg::sat_inc(hit_q);
          else miss_d = pctl_pkg::sat_inc(miss_q);
        end
        pctl_pkg::CMD_INSERT: begin
          if (evicted_q) evict_d = pctl_pkg::sat_inc(evict_q);
        end
        pctl_pkg::CMD_TICK: tick_d = tick_q + 1'b1;
        pctl_pkg::CMD_CLEAR: begin
          hit_d   = '0;
          miss_d  = '0;
          evict_d = '0;
        end
        default: tick_d = tick_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else begin
      tick_q  <= tick_d;
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      evict_q <= evict_d;
    end
  end

  // result register
  assign res_found = ((cmd_q == pctl_pkg::CMD_LOOKUP) || (cmd_q == pctl_pkg::CMD_REMOVE))
                     ? sel_found_q : (cmd_q == pctl_pkg::CMD_INSERT);
  assign rd_ext    = {{pctl_pkg::WDATA_W{1'b0}}, sel_entry_q[DW-1:0]};
  assign idx_ext   = {{pctl_pkg::SLOT_W{1'b0}}, sel_addr_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      found_q     <= res_found;
      rdata_out_q <= ((cmd_q == pctl_pkg::CMD_LOOKUP) && sel_found_q)
                     ? rd_ext[pctl_pkg::WDATA_W-1:0] : '0;
      idx_out_q   <= res_found ? idx_ext[pctl_pkg::SLOT_W-1:0] : '0;
      ev_out_q    <= (cmd_q == pctl_pkg::CMD_INSERT) && evicted_q;
    end
  end

  assign found_o          = found_q;
  assign read_data_o      = rdata_out_q;
  assign slot_index_o     = idx_out_q;
  assign evicted_o        = ev_out_q;
  assign hits_seen_o      = hit_q;
  assign misses_seen_o    = miss_q;
  assign evictions_seen_o = evict_q;

endmodule

/* verif/probing_cache_table_ttl_lru_test.sv */
// ----------------------------------------------------------------------------
// probing_cache_table_ttl_lru_test
// Self-checking bench for the probing cache table. A short table of
// directed commands is followed by random traffic that sticks to a few
// crowded probe windows, so that lookups, inserts, evictions, lifetime
// expiry, purges and clears all get exercised. Each result item is
// compared field by field with a software copy of the table or a typed row.
// ----------------------------------------------------------------------------
module probing_cache_table_ttl_lru_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_W       = pctl_pkg::CMD_W;
  localparam int unsigned KEY_W       = pctl_pkg::KEY_W;
  localparam int unsigned WDATA_W     = pctl_pkg::WDATA_W;
  localparam int unsigned LIFE_W      = pctl_pkg::LIFE_W;
  localparam int unsigned SLOT_W      = pctl_pkg::SLOT_W;
  localparam int unsigned CNT_W       = pctl_pkg::CNT_W;
  localparam int unsigned TIME_W      = pctl_pkg::TIME_W;
  localparam int unsigned CAPACITY    = pctl_pkg::CAPACITY;
  localparam int unsigned PROBE_LIMIT = pctl_pkg::PROBE_LIMIT;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int NO_SLOT      = -1;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int HOLD_CYCLES  = 2500;
  localparam int RAND_ITEMS   = 1800;
  localparam int POOL_SIZE    = 40;
  localparam int N_ROWS       = 22;

  typedef struct {
    logic                found;
    logic [WDATA_W-1:0]  rdata;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
    logic [CNT_W-1:0]    evictions;
  } answer_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [WDATA_W-1:0]  wdata;
    logic [LIFE_W-1:0]   life;
    bit                  typed;
    logic                t_found;
    logic [WDATA_W-1:0]  t_rdata;
    logic [SLOT_W-1:0]   t_slot;
    logic                t_ev;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CMD_W-1:0]   cmd_i = '0;
  logic [KEY_W-1:0]   key_digest_i = '0;
  logic [WDATA_W-1:0] write_data_i = '0;
  logic [LIFE_W-1:0]  lifetime_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o, evicted_o;
  logic [WDATA_W-1:0] read_data_o;
  logic [SLOT_W-1:0]  slot_index_o;
  logic [CNT_W-1:0]   hits_seen_o, misses_seen_o, evictions_seen_o;

  probing_cache_table_ttl_lru u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .key_digest_i,
    .write_data_i, .lifetime_i, .out_valid_o, .out_ready_i, .found_o,
    .read_data_o, .slot_index_o, .evicted_o, .hits_seen_o, .misses_seen_o,
    .evictions_seen_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // software copy of the table
  bit                 sw_live    [CAPACITY];
  bit [KEY_W-1:0]     sw_tag     [CAPACITY];
  bit [TIME_W-1:0]    sw_born    [CAPACITY];
  bit [TIME_W-1:0]    sw_touched [CAPACITY];
  bit [LIFE_W-1:0]    sw_life    [CAPACITY];
  bit [WDATA_W-1:0]   sw_payload [CAPACITY];
  bit [TIME_W-1:0]    sw_now;
  bit [CNT_W-1:0]     sw_hits, sw_misses, sw_evicts;

  answer_t pending_results[$];
  row_t    rows[N_ROWS];
  bit [KEY_W-1:0] key_pool[POOL_SIZE];
  int errors, n_items, n_results, n_hits, n_evicted, cycles;
  bit burst;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0h want %0h", n_results, what, got, want);
  endtask

  function automatic bit aged_out(int s);
    bit [TIME_W-1:0] age;
    age = sw_now - sw_born[s];
    return age > TIME_W'(sw_life[s]);
  endfunction

  function automatic int seek_slot(bit [KEY_W-1:0] key, bit for_insert);
    int base, s;
    base = int'(key % CAPACITY);
    for (int d = 0; d <= PROBE_LIMIT; d++) begin
      s = (base + d) % CAPACITY;
      if (!sw_live[s]) return for_insert ? s : NO_SLOT;
      if (sw_tag[s] == key && !aged_out(s)) return s;
    end
    return NO_SLOT;
  endfunction

  function automatic int lru_victim();
    bit [TIME_W:0] oldest;
    int pick;
    oldest = '1;
    pick = 0;
    for (int s = 0; s < CAPACITY; s++) begin
      if (!sw_live[s]) return s;
      if ({1'b0, sw_touched[s]} < oldest) begin
        oldest = {1'b0, sw_touched[s]};
        pick = s;
      end
    end
    return pick;
  endfunction

  function automatic bit [CNT_W-1:0] bump(bit [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // applies one command to the software table and returns its result item
  function automatic answer_t apply_command(logic [CMD_W-1:0] cmd, bit [KEY_W-1:0] key,
                                            bit [WDATA_W-1:0] wdata, bit [LIFE_W-1:0] life);
    answer_t a;
    int s;
    a = '{default: '0};
    case (cmd)
      pctl_pkg::CMD_LOOKUP: begin
        s = seek_slot(key, 1'b0);
        if (s == NO_SLOT) begin
          sw_misses = bump(sw_misses);
        end else begin
          sw_touched[s] = sw_now;
          sw_hits = bump(sw_hits);
          a.found = 1'b1;
          a.rdata = sw_payload[s];
          a.slot = SLOT_W'(s);
        end
      end
      pctl_pkg::CMD_INSERT: begin
        s = seek_slot(key, 1'b1);
        if (s == NO_SLOT) begin
          s = lru_victim();
          sw_evicts = bump(sw_evicts);
          a.evicted = 1'b1;
        end
        sw_live[s] = 1'b1;
        sw_tag[s] = key;
        sw_born[s] = sw_now;
        sw_touched[s] = sw_now;
        sw_life[s] = life;
        sw_payload[s] = wdata;
        a.found = 1'b1;
        a.slot = SLOT_W'(s);
      end
      pctl_pkg::CMD_REMOVE: begin
        s = seek_slot(key, 1'b0);
        if (s != NO_SLOT) begin
          sw_live[s] = 1'b0;
          a.found = 1'b1;
          a.slot = SLOT_W'(s);
        end
      end
      pctl_pkg::CMD_PURGE: begin
        for (int i = 0; i < CAPACITY; i++)
          if (sw_live[i] && aged_out(i)) sw_live[i] = 1'b0;
      end
      pctl_pkg::CMD_TICK: sw_now = sw_now + 1'b1;
      pctl_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) sw_live[i] = 1'b0;
        sw_hits = '0;
        sw_misses = '0;
        sw_evicts = '0;
      end
      default: ;
    endcase
    a.hits = sw_hits;
    a.misses = sw_misses;
    a.evictions = sw_evicts;
    return a;
  endfunction

  // offer one item and hold it until taken; valid stays high on return
  task automatic send_item(row_t r);
    answer_t a;
    in_valid_i   <= 1'b1;
    cmd_i        <= r.cmd;
    key_digest_i <= r.key;
    write_data_i <= r.wdata;
    lifetime_i   <= r.life;
    do @(posedge clk_i); while (!in_ready_o);
    a = apply_command(r.cmd, r.key, r.wdata, r.life);
    if (r.typed) begin
      a.found = r.t_found;
      a.rdata = r.t_rdata;
      a.slot = r.t_slot;
      a.evicted = r.t_ev;
    end
    pending_results.push_back(a);
    n_items++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (burst || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_sender();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic bit [KEY_W-1:0] crowded_key();
    bit [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    // bases near the top wrap around into slot zero
    k[SLOT_W-1:0] = SLOT_W'((1018 + $urandom_range(0, 11)) % CAPACITY);
    return k;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int p;
    r = '{default: '0};
    p = $urandom_range(0, 99);
    if (p < 35)      r.cmd = pctl_pkg::CMD_LOOKUP;
    else if (p < 65) r.cmd = pctl_pkg::CMD_INSERT;
    else if (p < 75) r.cmd = pctl_pkg::CMD_REMOVE;
    else if (p < 86) r.cmd = pctl_pkg::CMD_TICK;
    else if (p < 89) r.cmd = pctl_pkg::CMD_PURGE;
    else if (p < 91) r.cmd = pctl_pkg::CMD_CLEAR;
    else if (p < 92) r.cmd = CMD_SPARE_LO;
    else if (p < 93) r.cmd = CMD_SPARE_HI;
    else             r.cmd = pctl_pkg::CMD_LOOKUP;
    r.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
                                         : {$urandom, $urandom};
    r.wdata = {$urandom, $urandom};
    p = $urandom_range(0, 99);
    if (p < 65)      r.life = $urandom_range(0, 8);
    else if (p < 85) r.life = $urandom;
    else if (p < 93) r.life = '1;
    else             r.life = '0;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(1), 64'(0));
      end else begin
        w = pending_results.pop_front();
        if (found_o !== w.found) report_mismatch("found", 64'(found_o), 64'(w.found));
        if (read_data_o !== w.rdata) report_mismatch("read_data", read_data_o, w.rdata);
        if (slot_index_o !== w.slot)
          report_mismatch("slot_index", 64'(slot_index_o), 64'(w.slot));
        if (evicted_o !== w.evicted)
          report_mismatch("evicted", 64'(evicted_o), 64'(w.evicted));
        if (hits_seen_o !== w.hits)
          report_mismatch("hits_seen", 64'(hits_seen_o), 64'(w.hits));
        if (misses_seen_o !== w.misses)
          report_mismatch("misses_seen", 64'(misses_seen_o), 64'(w.misses));
        if (evictions_seen_o !== w.evictions)
          report_mismatch("evictions_seen", 64'(evictions_seen_o), 64'(w.evictions));
        n_hits += (w.found && w.rdata != 0) ? 1 : 0;
        n_evicted += w.evicted;
      end
    end
  end

  // result receiver, with one long hold-off so the block backs up
  initial begin
    int p;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_items > 400) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        p = $urandom_range(0, 99);
        if (burst || p < 70) begin
          out_ready_i <= 1'b1;
        end else if (p < 96) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(0, 3)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(10, 50)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rows[0]  = '{pctl_pkg::CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[1]  = '{pctl_pkg::CMD_INSERT, 64'h0, '1, 32'h0, 1, 1'b1, 64'h0, 10'd0, 1'b0};
    rows[2]  = '{pctl_pkg::CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 1, 1'b1, '1, 10'd0, 1'b0};
    rows[3]  = '{pctl_pkg::CMD_INSERT, '1, 64'h0, '1, 1, 1'b1, 64'h0, 10'd1023, 1'b0};
    // same base, different tag: wraps past the top slot
    rows[4]  = '{pctl_pkg::CMD_INSERT, 64'h3FF, 64'h1234_5678_9ABC_DEF0, 32'd7,
                 0, 0, 0, 0, 0};
    rows[5]  = '{pctl_pkg::CMD_LOOKUP, 64'h3FF, 64'h0, 32'h0, 0, 0, 0, 0, 0};
    rows[6]  = '{pctl_pkg::CMD_REMOVE, 64'h0, 64'h0, 32'h0, 1, 1'b1, 64'h0, 10'd0, 1'b0};
    // free slot in the window ends the probe
    rows[7]  = '{pctl_pkg::CMD_LOOKUP, 64'h3FF, 64'h0, 32'h0, 0, 0, 0, 0, 0};
    rows[8]  = '{pctl_pkg::CMD_REMOVE, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[9]  = '{pctl_pkg::CMD_TICK, '1, '1, '1, 0, 0, 0, 0, 0};
    rows[10] = '{pctl_pkg::CMD_INSERT, 64'h5, 64'hA5A5_5A5A_F00F_0FF0, 32'h0,
                 0, 0, 0, 0, 0};
    rows[11] = '{pctl_pkg::CMD_LOOKUP, 64'h5, 64'h0, 32'h0, 0, 0, 0, 0, 0};
    rows[12] = '{pctl_pkg::CMD_TICK, 64'h0, 64'h0, 32'h0, 0, 0, 0, 0, 0};
    // expired entry with the same tag is passed over
    rows[13] = '{pctl_pkg::CMD_LOOKUP, 64'h5, 64'h0, 32'h0, 0, 0, 0, 0, 0};
    rows[14] = '{pctl_pkg::CMD_INSERT, 64'h5, 64'h1, 32'd100, 0, 0, 0, 0, 0};
    rows[15] = '{pctl_pkg::CMD_INSERT, 64'h5, 64'h2, 32'd100, 0, 0, 0, 0, 0};
    rows[16] = '{pctl_pkg::CMD_PURGE, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[17] = '{CMD_SPARE_LO, 64'h5, '1, '1, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[18] = '{CMD_SPARE_HI, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[19] = '{pctl_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 64'h7, 32'h0,
                 0, 0, 0, 0, 0};
    rows[20] = '{pctl_pkg::CMD_CLEAR, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    rows[21] = '{pctl_pkg::CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 1, 1'b0, 64'h0, 10'd0, 1'b0};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = crowded_key();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      send_item(rows[i]);
      idle_sender();
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i % 300 == 299) key_pool[$urandom_range(0, POOL_SIZE-1)] = crowded_key();
      send_item(random_row());
      idle_sender();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d lookup hits with data, %0d evictions",
             n_items, n_results, n_hits, n_evicted);
    $display("%0d mismatches after %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
